// File: rtl/core/tcg_pkg.sv
`default_nettype none

package tcg_pkg;

    // Input event codes.
    localparam logic [2:0] MODE_TOGGLE = 3'd0;
    localparam logic [2:0] MODE_CHAR   = 3'd1;
    localparam logic [2:0] MODE_ENTER  = 3'd2;
    localparam logic [2:0] MODE_BKSP   = 3'd3;
    localparam logic [2:0] MODE_READ   = 3'd4;

    // Character codes.
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_DOLLAR    = 8'h24;
    localparam logic [7:0] CH_BACKQUOTE = 8'h60;
    localparam logic [7:0] CH_TILDE     = 8'h7E;
    localparam logic [7:0] CH_FIRST     = 8'h20;
    localparam logic [7:0] CH_LAST      = 8'h7E;

    // Command queue between the front and the back.
    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);

    typedef enum logic [2:0] {
        K_TOGGLE,
        K_CHAR,
        K_ENTER,
        K_BKSP,
        K_READ,
        K_NOP
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] code;
        logic [4:0] row;
        logic [5:0] col;
    } t_cmd;

    typedef struct packed {
        logic       consumed;
        logic [7:0] cell_char;
        logic [4:0] cursor_row;
        logic [5:0] cursor_col;
        logic       console_on;
        logic [8:0] line_count;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/core/text_console_grid_with_scroll_core.sv
// Channel   Handshake             Payload
// input     push / full           i_mode, i_char_code, i_read_row, i_read_col
// result    empty / pop           o_consumed, o_cell_char, o_cursor_row,
//                                 o_cursor_col, o_console_on, o_line_count
//
// Events run one at a time through the grid sequencer: toggle and no-op
// events go straight to the result, a printed character, backspace or read
// pass S_PUT, S_WIPE or S_READ first, enter puts newline, dollar and space,
// and passing the last row adds S_SCROLL, where the single write port clears
// the new bottom row. After reset the grid RAM is swept one cell a cycle and
// full stays high meanwhile. A two-entry command queue keeps push open while
// the sequencer works or while a result waits on the one-deep result register.
`default_nettype none

module text_console_grid_with_scroll_core #(
    parameter int ROWS     = 32,
    parameter int COLS     = 64,
    parameter int LINE_MAX = 256
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [2:0] i_mode,
    input  wire logic [7:0] i_char_code,
    input  wire logic [4:0] i_read_row,
    input  wire logic [5:0] i_read_col,
    output logic            empty,
    input  wire logic       pop,
    output logic            o_consumed,
    output logic [7:0]      o_cell_char,
    output logic [4:0]      o_cursor_row,
    output logic [5:0]      o_cursor_col,
    output logic            o_console_on,
    output logic [8:0]      o_line_count
);

    tcg_pkg::t_cmd     cmd;
    logic              cmd_valid;
    logic              cmd_pop;
    logic              clearing;
    logic              res_valid;
    tcg_pkg::t_result  res;

    tcg_front #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_hold      (clearing),
        .o_full      (full),
        .i_mode      (i_mode),
        .i_char_code (i_char_code),
        .i_read_row  (i_read_row),
        .i_read_col  (i_read_col),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    tcg_back #(
        .ROWS     (ROWS),
        .COLS     (COLS),
        .LINE_MAX (LINE_MAX)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_clearing  (clearing),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_pop   (pop)
    );

    assign empty        = !res_valid;
    assign o_consumed   = res.consumed;
    assign o_cell_char  = res.cell_char;
    assign o_cursor_row = res.cursor_row;
    assign o_cursor_col = res.cursor_col;
    assign o_console_on = res.console_on;
    assign o_line_count = res.line_count;

`ifndef SYNTHESIS
    // Reset starts the grid sweep: no result and no intake right after it.
    a_reset_sweep: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && full))
        else $error("result or intake open right after reset");

    a_consumed_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_consumed) |-> o_console_on)
        else $error("character consumed while console disabled");

    a_cursor_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (32'(o_cursor_col) < COLS))
        else $error("cursor column past the last column");

    a_line_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (32'(o_line_count) <= LINE_MAX))
        else $error("line count above the line limit");
`endif

endmodule

`default_nettype wire

// File: rtl/core/tcg_ram.sv
`default_nettype none

module tcg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/core/tcg_front.sv
`default_nettype none

module tcg_front #(
    parameter int ROWS = 32,
    parameter int COLS = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire logic          i_hold,
    output logic               o_full,
    input  wire logic [2:0]    i_mode,
    input  wire logic [7:0]    i_char_code,
    input  wire logic [4:0]    i_read_row,
    input  wire logic [5:0]    i_read_col,
    output logic               o_cmd_valid,
    output tcg_pkg::t_cmd      o_cmd,
    input  wire logic          i_cmd_pop
);

    tcg_pkg::t_cmd                  cmd_in;
    tcg_pkg::t_cmd                  r_q [tcg_pkg::QDEPTH];
    logic [tcg_pkg::QAW-1:0]        r_wp;
    logic [tcg_pkg::QAW-1:0]        r_rp;
    logic [tcg_pkg::QAW:0]          r_cnt;
    logic                           push_ok;
    logic                           pop_ok;

    // Characters that can never be printed, reads outside the grid and spare event
    // codes change nothing, so they are reduced to a no-op here.
    always_comb begin
        cmd_in.code = i_char_code;
        cmd_in.row  = i_read_row;
        cmd_in.col  = i_read_col;
        unique case (i_mode)
            tcg_pkg::MODE_TOGGLE: cmd_in.kind = tcg_pkg::K_TOGGLE;
            tcg_pkg::MODE_CHAR: begin
                if (i_char_code >= tcg_pkg::CH_FIRST && i_char_code <= tcg_pkg::CH_LAST &&
                    i_char_code != tcg_pkg::CH_BACKQUOTE &&
                    i_char_code != tcg_pkg::CH_TILDE) begin
                    cmd_in.kind = tcg_pkg::K_CHAR;
                end else begin
                    cmd_in.kind = tcg_pkg::K_NOP;
                end
            end
            tcg_pkg::MODE_ENTER: cmd_in.kind = tcg_pkg::K_ENTER;
            tcg_pkg::MODE_BKSP:  cmd_in.kind = tcg_pkg::K_BKSP;
            tcg_pkg::MODE_READ: begin
                if (32'(i_read_row) < ROWS && 32'(i_read_col) < COLS) begin
                    cmd_in.kind = tcg_pkg::K_READ;
                end else begin
                    cmd_in.kind = tcg_pkg::K_NOP;
                end
            end
            default: cmd_in.kind = tcg_pkg::K_NOP;
        endcase
    end

    assign o_full      = (r_cnt == (tcg_pkg::QAW+1)'(tcg_pkg::QDEPTH)) || i_hold;
    assign push_ok     = i_push && !o_full;
    assign o_cmd_valid = (r_cnt != '0);
    assign pop_ok      = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop_ok) begin
                r_rp <= r_rp + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wp] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/tcg_back.sv
`default_nettype none

module tcg_back #(
    parameter int ROWS     = 32,
    parameter int COLS     = 64,
    parameter int LINE_MAX = 256
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cmd_valid,
    input  wire tcg_pkg::t_cmd i_cmd,
    output logic               o_cmd_pop,
    output logic               o_clearing,
    output logic               o_res_valid,
    output tcg_pkg::t_result   o_res,
    input  wire logic          i_res_pop
);

    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS);
    localparam int CELLS = ROWS * COLS;
    localparam int AW    = $clog2(CELLS);
    localparam int LW    = $clog2(LINE_MAX + 1);

    // With only two columns the prompt itself wraps onto the second row.
    localparam logic [RW-1:0] RST_ROW = (COLS > 2) ? RW'(0) : RW'(1);
    localparam logic [CW-1:0] RST_COL = (COLS > 2) ? CW'(2) : CW'(0);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PUT,
        S_SCROLL,
        S_WIPE,
        S_READ,
        S_DONE
    } t_state;

    // Characters of the prompt still to print after an enter.
    typedef enum logic [1:0] {
        PH_NONE,
        PH_DOLLAR,
        PH_SPACE
    } t_phase;

    t_state            r_state,    n_state;
    t_phase            r_phase,    n_phase;
    logic [AW-1:0]     r_addr,     n_addr;
    logic [RW-1:0]     r_row,      n_row;
    logic [CW-1:0]     r_col,      n_col;
    logic [RW-1:0]     r_top,      n_top;
    logic              r_on,       n_on;
    logic [LW-1:0]     r_count,    n_count;
    logic [7:0]        r_pend,     n_pend;
    logic              r_consumed, n_consumed;
    logic [7:0]        r_cell,     n_cell;
    logic [AW-1:0]     r_clr_base, n_clr_base;
    logic [CW-1:0]     r_sc_col,   n_sc_col;
    tcg_pkg::t_result  r_res,      n_res;
    logic              r_res_valid, n_res_valid;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [7:0]        ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [7:0]        ram_rdata;
    logic [AW-1:0]     cur_addr;
    logic [AW-1:0]     rd_addr;
    logic [CW:0]       col_inc;
    logic              wrap;
    logic              put_end;

    // Displayed row r lives in stored row (top + r) mod ROWS.
    function automatic logic [AW-1:0] f_addr(input logic [RW-1:0] top,
                                             input logic [RW-1:0] row,
                                             input logic [CW-1:0] col);
        logic [RW:0]   sum;
        logic [RW:0]   diff;
        logic [RW-1:0] prow;
        sum  = {1'b0, top} + {1'b0, row};
        diff = sum - (RW+1)'(ROWS);
        if (sum >= (RW+1)'(ROWS)) begin
            prow = diff[RW-1:0];
        end else begin
            prow = sum[RW-1:0];
        end
        return AW'(prow * COLS) + AW'(col);
    endfunction

    assign cur_addr = f_addr(r_top, r_row, r_col);
    assign rd_addr  = f_addr(r_top, RW'(i_cmd.row), CW'(i_cmd.col));
    assign col_inc  = {1'b0, r_col} + 1'b1;

    tcg_ram #(
        .WIDTH (8),
        .DEPTH (CELLS)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_addr      = r_addr;
        n_row       = r_row;
        n_col       = r_col;
        n_top       = r_top;
        n_on        = r_on;
        n_count     = r_count;
        n_pend      = r_pend;
        n_consumed  = r_consumed;
        n_cell      = r_cell;
        n_clr_base  = r_clr_base;
        n_sc_col    = r_sc_col;
        n_res       = r_res;
        n_res_valid = r_res_valid;
        ram_we      = 1'b0;
        ram_waddr   = cur_addr;
        ram_wdata   = '0;
        ram_raddr   = rd_addr;
        o_cmd_pop   = 1'b0;
        wrap        = 1'b0;
        put_end     = 1'b0;

        if (i_res_pop && r_res_valid) begin
            n_res_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                // One cell per cycle; the prompt lands in the first two cells.
                ram_we    = 1'b1;
                ram_waddr = r_addr;
                if (r_addr == AW'(0)) begin
                    ram_wdata = tcg_pkg::CH_DOLLAR;
                end else if (r_addr == AW'(1)) begin
                    ram_wdata = tcg_pkg::CH_SPACE;
                end
                n_addr = r_addr + 1'b1;
                if (r_addr == AW'(CELLS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_cmd_valid && !r_res_valid) begin
                    o_cmd_pop  = 1'b1;
                    n_consumed = 1'b0;
                    n_cell     = '0;
                    n_phase    = PH_NONE;
                    unique case (i_cmd.kind)
                        tcg_pkg::K_TOGGLE: begin
                            n_on    = !r_on;
                            n_state = S_DONE;
                        end
                        tcg_pkg::K_CHAR: begin
                            n_state = S_DONE;
                            if (r_on) begin
                                n_consumed = 1'b1;
                                if (r_count < LW'(LINE_MAX)) begin
                                    n_count = r_count + 1'b1;
                                    n_pend  = i_cmd.code;
                                    n_state = S_PUT;
                                end
                            end
                        end
                        tcg_pkg::K_ENTER: begin
                            n_count = '0;
                            n_pend  = tcg_pkg::CH_NEWLINE;
                            n_phase = PH_DOLLAR;
                            n_state = S_PUT;
                        end
                        tcg_pkg::K_BKSP: begin
                            n_state = S_DONE;
                            if (r_count != '0) begin
                                n_count = r_count - 1'b1;
                                n_state = S_WIPE;
                                if (r_col == '0) begin
                                    if (r_row != '0) begin
                                        n_col = CW'(COLS - 1);
                                        n_row = r_row - 1'b1;
                                    end
                                end else begin
                                    n_col = r_col - 1'b1;
                                end
                            end
                        end
                        tcg_pkg::K_READ: begin
                            n_state = S_READ;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_PUT: begin
                if (r_pend == tcg_pkg::CH_NEWLINE) begin
                    wrap = 1'b1;
                end else begin
                    ram_we    = 1'b1;
                    ram_wdata = r_pend;
                    n_col     = col_inc[CW-1:0];
                    wrap      = (col_inc >= (CW+1)'(COLS));
                end
                if (wrap) begin
                    n_col = '0;
                    if (r_row == RW'(ROWS - 1)) begin
                        // Scroll: the old top row becomes the cleared bottom row.
                        n_clr_base = AW'(r_top * COLS);
                        n_top      = (r_top == RW'(ROWS - 1)) ? '0 : r_top + 1'b1;
                        n_sc_col   = '0;
                        n_state    = S_SCROLL;
                    end else begin
                        n_row   = r_row + 1'b1;
                        put_end = 1'b1;
                    end
                end else begin
                    put_end = 1'b1;
                end
            end
            S_SCROLL: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_base + AW'(r_sc_col);
                n_sc_col  = r_sc_col + 1'b1;
                if (r_sc_col == CW'(COLS - 1)) begin
                    put_end = 1'b1;
                end
            end
            S_WIPE: begin
                ram_we  = 1'b1;
                n_state = S_DONE;
            end
            S_READ: begin
                n_cell  = ram_rdata;
                n_state = S_DONE;
            end
            S_DONE: begin
                n_res.consumed   = r_consumed;
                n_res.cell_char  = r_cell;
                n_res.cursor_row = 5'(r_row);
                n_res.cursor_col = 6'(r_col);
                n_res.console_on = r_on;
                n_res.line_count = 9'(r_count);
                n_res_valid      = 1'b1;
                n_state          = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (put_end) begin
            unique case (r_phase)
                PH_DOLLAR: begin
                    n_pend  = tcg_pkg::CH_DOLLAR;
                    n_phase = PH_SPACE;
                    n_state = S_PUT;
                end
                PH_SPACE: begin
                    n_pend  = tcg_pkg::CH_SPACE;
                    n_phase = PH_NONE;
                    n_state = S_PUT;
                end
                default: begin
                    n_state = S_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_phase     <= PH_NONE;
            r_addr      <= '0;
            r_row       <= RST_ROW;
            r_col       <= RST_COL;
            r_top       <= '0;
            r_on        <= 1'b0;
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_addr      <= n_addr;
            r_row       <= n_row;
            r_col       <= n_col;
            r_top       <= n_top;
            r_on        <= n_on;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_consumed  <= n_consumed;
            r_cell      <= n_cell;
            r_clr_base  <= n_clr_base;
            r_sc_col    <= n_sc_col;
            r_res       <= n_res;
            r_res_valid <= n_res_valid;
        end
    end

    assign o_clearing  = (r_state == S_CLEAR);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

`default_nettype wire

// File: verif/text_console_grid_with_scroll_core_tb.sv
module text_console_grid_with_scroll_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROWS         = 32;
    localparam int COLS         = 64;
    localparam int LINE_MAX     = 256;
    localparam int ITEM_TARGET  = 1350;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 100;
    localparam int PRINT_CAP    = 40;

    // Event codes that the block must treat as no-ops.
    localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;

    logic       i_clk;
    logic       i_rst_n;
    logic       push;
    logic       full;
    logic [2:0] i_mode;
    logic [7:0] i_char_code;
    logic [4:0] i_read_row;
    logic [5:0] i_read_col;
    logic       empty;
    logic       pop = 1'b0;
    logic       o_consumed;
    logic [7:0] o_cell_char;
    logic [4:0] o_cursor_row;
    logic [5:0] o_cursor_col;
    logic       o_console_on;
    logic [8:0] o_line_count;

    class console_tracker;
        logic [7:0]        grid [ROWS*COLS];
        logic [4:0]        cur_row;
        logic [5:0]        cur_col;
        logic [4:0]        top_base;
        logic              enabled;
        logic [8:0]        typed;
        tcg_pkg::t_result  awaited [$];
        int                errors;
        int                checked;

        function new();
            foreach (grid[i]) grid[i] = '0;
            cur_row  = '0;
            cur_col  = '0;
            top_base = '0;
            enabled  = 1'b0;
            typed    = '0;
            errors   = 0;
            checked  = 0;
            print_char(tcg_pkg::CH_DOLLAR);
            print_char(tcg_pkg::CH_SPACE);
        endfunction

        static function bit typable(logic [7:0] code);
            return code >= tcg_pkg::CH_FIRST && code <= tcg_pkg::CH_LAST &&
                   code != tcg_pkg::CH_BACKQUOTE && code != tcg_pkg::CH_TILDE;
        endfunction

        function int cell_index(logic [4:0] row, logic [5:0] col);
            return ((int'(top_base) + int'(row)) % ROWS) * COLS + int'(col);
        endfunction

        // Leaving the last row scrolls: the old top row becomes the new bottom row.
        function void advance_row();
            cur_col = '0;
            if (int'(cur_row) == ROWS - 1) begin
                for (int c = 0; c < COLS; c++) grid[int'(top_base) * COLS + c] = '0;
                top_base = (int'(top_base) == ROWS - 1) ? '0 : top_base + 1'b1;
            end else begin
                cur_row = cur_row + 1'b1;
            end
        endfunction

        function void print_char(logic [7:0] code);
            if (code == tcg_pkg::CH_NEWLINE) begin
                advance_row();
            end else begin
                grid[cell_index(cur_row, cur_col)] = code;
                if (int'(cur_col) == COLS - 1) advance_row();
                else cur_col = cur_col + 1'b1;
            end
        endfunction

        function void apply_event(logic [2:0] mode, logic [7:0] code,
                                  logic [4:0] row, logic [5:0] col);
            tcg_pkg::t_result r;
            r = '0;
            case (mode)
                tcg_pkg::MODE_TOGGLE: begin
                    enabled = ~enabled;
                end
                tcg_pkg::MODE_CHAR: begin
                    if (enabled && typable(code)) begin
                        r.consumed = 1'b1;
                        if (typed < LINE_MAX) begin
                            typed = typed + 1'b1;
                            print_char(code);
                        end
                    end
                end
                tcg_pkg::MODE_ENTER: begin
                    print_char(tcg_pkg::CH_NEWLINE);
                    typed = '0;
                    print_char(tcg_pkg::CH_DOLLAR);
                    print_char(tcg_pkg::CH_SPACE);
                end
                tcg_pkg::MODE_BKSP: begin
                    if (typed != 0) begin
                        typed = typed - 1'b1;
                        if (cur_col == 0) begin
                            if (cur_row != 0) begin
                                cur_col = 6'(COLS - 1);
                                cur_row = cur_row - 1'b1;
                            end
                        end else begin
                            cur_col = cur_col - 1'b1;
                        end
                        grid[cell_index(cur_row, cur_col)] = '0;
                    end
                end
                tcg_pkg::MODE_READ: begin
                    if (int'(row) < ROWS && int'(col) < COLS)
                        r.cell_char = grid[cell_index(row, col)];
                end
                default: begin
                end
            endcase
            r.cursor_row = cur_row;
            r.cursor_col = cur_col;
            r.console_on = enabled;
            r.line_count = typed;
            awaited.push_back(r);
        endfunction

        task report_mismatch(string what, int unsigned seen, int unsigned wanted);
            errors++;
            if (errors <= PRINT_CAP)
                $display("ERROR: transaction %0d, %s: got 0x%0h, expected 0x%0h",
                         checked, what, seen, wanted);
        endtask

        task check_report(tcg_pkg::t_result got);
            tcg_pkg::t_result want;
            checked++;
            if (awaited.size() == 0) begin
                report_mismatch("result with nothing pending", got, 0);
            end else begin
                want = awaited.pop_front();
                if (got.consumed !== want.consumed)
                    report_mismatch("consumed", got.consumed, want.consumed);
                if (got.cell_char !== want.cell_char)
                    report_mismatch("cell_char", got.cell_char, want.cell_char);
                if (got.cursor_row !== want.cursor_row)
                    report_mismatch("cursor_row", got.cursor_row, want.cursor_row);
                if (got.cursor_col !== want.cursor_col)
                    report_mismatch("cursor_col", got.cursor_col, want.cursor_col);
                if (got.console_on !== want.console_on)
                    report_mismatch("console_on", got.console_on, want.console_on);
                if (got.line_count !== want.line_count)
                    report_mismatch("line_count", got.line_count, want.line_count);
            end
        endtask
    endclass

    console_tracker tracker;
    int unsigned    cycle_count = 0;
    int unsigned    sent_items  = 0;
    int unsigned    burst_left  = 1;
    logic [10:0]    rx_phase    = '0;
    bit             console_is_on = 1'b0;

    text_console_grid_with_scroll_core #(
        .ROWS     (ROWS),
        .COLS     (COLS),
        .LINE_MAX (LINE_MAX)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_mode       (i_mode),
        .i_char_code  (i_char_code),
        .i_read_row   (i_read_row),
        .i_read_col   (i_read_col),
        .empty        (empty),
        .pop          (pop),
        .o_consumed   (o_consumed),
        .o_cell_char  (o_cell_char),
        .o_cursor_row (o_cursor_row),
        .o_cursor_col (o_cursor_col),
        .o_console_on (o_console_on),
        .o_line_count (o_line_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Inputs are noted before results are checked, both in one process.
    always @(posedge i_clk) begin
        tcg_pkg::t_result got;
        if (i_rst_n && push && !full)
            tracker.apply_event(i_mode, i_char_code, i_read_row, i_read_col);
        if (i_rst_n && pop && !empty) begin
            got = {o_consumed, o_cell_char, o_cursor_row, o_cursor_col,
                   o_console_on, o_line_count};
            tracker.check_report(got);
        end
    end

    // The receiver cycles through free-running, random, sparse and blocky stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            rx_phase <= rx_phase + 1'b1;
            case (rx_phase[10:9])
                2'd0: pop <= 1'b1;
                2'd1: pop <= ($urandom_range(0, 3) != 0);
                2'd2: pop <= (rx_phase[2:0] == 3'd0);
                default: pop <= rx_phase[4];
            endcase
        end
    end

    task automatic send_event(logic [2:0] mode, logic [7:0] code,
                              logic [4:0] row, logic [5:0] col);
        int gap;
        push        <= 1'b1;
        i_mode      <= mode;
        i_char_code <= code;
        i_read_row  <= row;
        i_read_col  <= col;
        do @(posedge i_clk); while (full);
        // Refused characters and spare codes do not count toward the item budget.
        if ((mode == tcg_pkg::MODE_CHAR) ? (console_is_on && console_tracker::typable(code))
                                         : (mode <= tcg_pkg::MODE_READ))
            sent_items++;
        if (mode == tcg_pkg::MODE_TOGGLE) console_is_on = !console_is_on;
        if (burst_left > 1) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
            gap = $urandom_range(0, 12);
            if (gap != 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic send_plain(logic [2:0] mode);
        send_event(mode, 8'($urandom), 5'($urandom), 6'($urandom));
    endtask

    task automatic send_char(logic [7:0] code);
        send_event(tcg_pkg::MODE_CHAR, code, 5'($urandom), 6'($urandom));
    endtask

    task automatic send_read(logic [4:0] row, logic [5:0] col);
        send_event(tcg_pkg::MODE_READ, 8'($urandom), row, col);
    endtask

    task automatic wait_all_results();
        push <= 1'b0;
        @(posedge i_clk);
        while (tracker.awaited.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] printable();
        logic [7:0] c;
        do c = 8'($urandom_range(tcg_pkg::CH_FIRST, tcg_pkg::CH_LAST));
        while (!console_tracker::typable(c));
        return c;
    endfunction

    // One input line; without edits it runs into the line limit.
    task automatic type_line(int len, bit edits);
        int pick;
        if (!console_is_on) send_plain(tcg_pkg::MODE_TOGGLE);
        for (int i = 0; i < len; i++) begin
            pick = edits ? $urandom_range(0, 99) : 99;
            if (pick < 6) repeat ($urandom_range(1, 4)) send_plain(tcg_pkg::MODE_BKSP);
            else if (pick < 10) send_read(5'($urandom), 6'($urandom));
            else if (pick < 14) send_read(tracker.cur_row, 6'($urandom));
            else if (pick < 17) send_char(8'($urandom));
            else send_char(printable());
        end
        if (!edits) begin
            send_char(printable());
            send_plain(tcg_pkg::MODE_BKSP);
            send_read(tracker.cur_row, 6'($urandom));
        end
        if ($urandom_range(0, 9) != 0) send_plain(tcg_pkg::MODE_ENTER);
    endtask

    initial begin
        int pick;
        tracker     = new();
        i_rst_n     = 1'b0;
        push        = 1'b0;
        i_mode      = tcg_pkg::MODE_TOGGLE;
        i_char_code = '0;
        i_read_row  = '0;
        i_read_col  = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_read(5'd0, 6'd0);
        send_read(5'd0, 6'd1);
        send_char(8'h41);               // console still off, so refused
        send_plain(tcg_pkg::MODE_TOGGLE);
        send_char(8'h00);
        send_char(tcg_pkg::CH_FIRST - 1'b1);
        send_char(tcg_pkg::CH_FIRST);
        send_char(tcg_pkg::CH_BACKQUOTE);
        send_char(tcg_pkg::CH_TILDE);
        send_char(tcg_pkg::CH_LAST + 1'b1);
        send_char(8'hFF);
        send_char(tcg_pkg::CH_TILDE - 1'b1);
        send_read(5'd0, 6'd3);
        send_plain(tcg_pkg::MODE_TOGGLE);
        send_plain(tcg_pkg::MODE_BKSP);     // editing keys still act with the console off
        send_plain(tcg_pkg::MODE_ENTER);
        send_plain(tcg_pkg::MODE_BKSP);     // nothing left on the line to erase
        send_plain(tcg_pkg::MODE_TOGGLE);
        for (int m = MODE_SPARE_FIRST; m <= MODE_SPARE_LAST; m++) send_plain(3'(m));
        send_read(5'(ROWS - 1), 6'(COLS - 1));
        wait_all_results();

        type_line(LINE_MAX + $urandom_range(2, 10), 1'b0);
        while (sent_items < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) type_line($urandom_range(0, 20), 1'b1);
            else if (pick < 78) type_line($urandom_range(40, 140), 1'b1);
            else if (pick < 80) type_line(LINE_MAX + $urandom_range(1, 6), 1'b0);
            else repeat ($urandom_range(1, 6))
                send_event(3'($urandom), 8'($urandom), 5'($urandom), 6'($urandom));
            if ($urandom_range(0, 24) == 0) wait_all_results();
        end

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.awaited.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: files.f
rtl/core/tcg_pkg.sv
rtl/core/tcg_ram.sv
rtl/core/tcg_front.sv
rtl/core/tcg_back.sv
rtl/core/text_console_grid_with_scroll_core.sv
verif/text_console_grid_with_scroll_core_tb.sv
